// ===== hdl/oxc_pkg.sv =====
// shared types and constants for the order crossover child builder
package oxc_pkg;

  localparam int CITY_W         = 6;
  localparam int COUNT_W        = 7;
  localparam int MODE_W         = 2;
  localparam int CITY_SPACE     = 64;
  localparam int MAX_CITIES_DEF = 64;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [COUNT_W-1:0] CITY_COUNT_RST = 7'd64;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [MODE_W-1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BUILD       = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_BUILD       = 2'd2
  } cmd_t;

  // a: position or clamped cut start, b: city or clamped cut end, n: tour length
  typedef struct packed {
    cmd_t                kind;
    logic [CITY_W-1:0]   a;
    logic [CITY_W-1:0]   b;
    logic [COUNT_W-1:0]  n;
  } q_entry_t;

endpackage

// ===== hdl/order_crossover_child.sv =====
// top level of the order crossover child builder
//
//   channel  | direction | contents
//   in_      | slave     | tuser: mode; tdata: position, city, cut_start, cut_end
//   out_     | master    | tdata: child_position, child_city; tlast: last
//   cfg_     | write     | city_count
//
// a load is written to its parent memory as the builder pops it; the queue lets the front keep taking loads meanwhile.
// a build of N cities with a segment of L entries does a copy and a fill walk over the
// parent memories, then emits N outputs at one per clock while the output is not stalled.
// throughput is set by the single child memory write port and the sequential walks.
// reset is synchronous and active low; it empties the queue and clears city_count to 64.
// a stalled output holds its transaction; the builder takes the next command once idle.
module order_crossover_child #(
  parameter int MaxCities = oxc_pkg::MAX_CITIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [oxc_pkg::COUNT_W-1:0]     cfg_wr_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [oxc_pkg::MODE_W-1:0]      in_tuser,   // mode
  input  logic [oxc_pkg::IN_TDATA_W-1:0]  in_tdata,   // position, city, cut_start, cut_end
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [oxc_pkg::OUT_TDATA_W-1:0] out_tdata,  // child_position, child_city
  output logic                            out_tlast
);

  logic              push;
  oxc_pkg::q_entry_t push_entry;
  logic              q_full;
  logic              q_pop;
  oxc_pkg::q_entry_t q_entry;
  logic              q_empty;

  oxc_front #(
    .MaxCities (MaxCities)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .push        (push),
    .push_entry  (push_entry),
    .q_full      (q_full)
  );

  oxc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_entry),
    .empty      (q_empty)
  );

  oxc_back #(
    .MaxCities (MaxCities)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hdl/oxc_front.sv =====
// front end: holds city_count, classifies transactions and clamps cut points
module oxc_front #(
  parameter int MaxCities = oxc_pkg::MAX_CITIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [oxc_pkg::COUNT_W-1:0]    cfg_wr_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [oxc_pkg::MODE_W-1:0]     in_tuser,
  input  logic [oxc_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           push,
  output oxc_pkg::q_entry_t              push_entry,
  input  logic                           q_full
);

  logic [oxc_pkg::COUNT_W-1:0] city_count_r;
  logic [oxc_pkg::COUNT_W-1:0] n_eff;
  logic [oxc_pkg::COUNT_W-1:0] n_m1;
  logic [oxc_pkg::CITY_W-1:0]  pos;
  logic [oxc_pkg::CITY_W-1:0]  city;
  logic [oxc_pkg::CITY_W-1:0]  cut_s;
  logic [oxc_pkg::CITY_W-1:0]  cut_e;
  logic                        pos_ok;
  logic                        keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= oxc_pkg::CITY_COUNT_RST;
    end else if (cfg_wr_en) begin
      city_count_r <= cfg_wr_data;
    end
  end

  assign pos   = in_tdata[5:0];
  assign city  = in_tdata[11:6];
  assign cut_s = in_tdata[17:12];
  assign cut_e = in_tdata[23:18];

  always_comb begin
    if (city_count_r == '0) begin
      n_eff = 7'd1;
    end else if (city_count_r > oxc_pkg::COUNT_W'(MaxCities)) begin
      n_eff = oxc_pkg::COUNT_W'(MaxCities);
    end else begin
      n_eff = city_count_r;
    end
  end

  assign n_m1   = n_eff - 7'd1;
  assign pos_ok = {1'b0, pos} < oxc_pkg::COUNT_W'(MaxCities);

  always_comb begin
    push_entry.n = n_eff;
    keep         = 1'b0;
    case (in_tuser)
      oxc_pkg::MODE_LOAD_FIRST: begin
        push_entry.kind = oxc_pkg::CMD_LOAD_FIRST;
        push_entry.a    = pos;
        push_entry.b    = city;
        keep            = pos_ok;
      end
      oxc_pkg::MODE_LOAD_SECOND: begin
        push_entry.kind = oxc_pkg::CMD_LOAD_SECOND;
        push_entry.a    = pos;
        push_entry.b    = city;
        keep            = pos_ok;
      end
      oxc_pkg::MODE_BUILD: begin
        push_entry.kind = oxc_pkg::CMD_BUILD;
        push_entry.a    = ({1'b0, cut_s} > n_m1) ? n_m1[5:0] : cut_s;
        push_entry.b    = ({1'b0, cut_e} > n_m1) ? n_m1[5:0] : cut_e;
        keep            = 1'b1;
      end
      default: begin
        // unused mode is taken and dropped
        push_entry.kind = oxc_pkg::CMD_BUILD;
        push_entry.a    = pos;
        push_entry.b    = city;
        keep            = 1'b0;
      end
    endcase
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready && keep;

endmodule

// ===== hdl/oxc_queue.sv =====
// short command queue between the front end and the builder
module oxc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  oxc_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output oxc_pkg::q_entry_t pop_entry,
  output logic              empty
);

  oxc_pkg::q_entry_t                slot_r [oxc_pkg::QDEPTH];
  logic [oxc_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [oxc_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [oxc_pkg::QCNT_W-1:0]       cnt_r;
  logic [oxc_pkg::QCNT_W-1:0]       cnt_nxt;

  assign full      = cnt_r == oxc_pkg::QCNT_W'(oxc_pkg::QDEPTH);
  assign empty     = cnt_r == '0;
  assign pop_entry = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 3'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hdl/oxc_back.sv =====
// builder: parent tour memories, segment copy, fill walk and child emission
module oxc_back #(
  parameter int MaxCities = oxc_pkg::MAX_CITIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  oxc_pkg::q_entry_t               q_entry,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [oxc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  localparam int AW = $clog2(MaxCities);
  localparam int CW = $clog2(MaxCities + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_FILL,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t                       state_r;
  logic [CW-1:0]                n_r;
  logic [AW-1:0]                e_r;
  logic [CW-1:0]                idx_r;
  logic [CW-1:0]                idx_inc;
  logic [AW-1:0]                cur_r;
  logic [CW-1:0]                cur_inc;

  logic [oxc_pkg::CITY_W-1:0]   fp_mem [MaxCities];
  logic [oxc_pkg::CITY_W-1:0]   sp_mem [MaxCities];
  logic [oxc_pkg::CITY_W-1:0]   child_mem [MaxCities];
  logic [oxc_pkg::CITY_W-1:0]   fp_rdata_r;
  logic [oxc_pkg::CITY_W-1:0]   sp_rdata_r;
  logic [oxc_pkg::CITY_W-1:0]   child_rdata_r;
  logic [oxc_pkg::CITY_SPACE-1:0] taken_r;
  logic [MaxCities-1:0]         written_r;

  logic                         seg_vld_r;
  logic [AW-1:0]                seg_idx_r;
  logic                         fill_vld_r;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [oxc_pkg::CITY_W-1:0]   wr_data;

  logic                         advance;
  logic                         issue_emit;
  logic                         p_vld_r;
  logic [AW-1:0]                p_idx_r;
  logic                         p_last_r;
  logic                         p_wr_r;
  logic                         out_valid_r;
  logic [oxc_pkg::CITY_W-1:0]   out_pos_r;
  logic [oxc_pkg::CITY_W-1:0]   out_city_r;
  logic                         out_last_r;

  logic                         start_build;

  assign q_pop       = (state_r == ST_IDLE) && !q_empty;
  assign start_build = q_pop && (q_entry.kind == oxc_pkg::CMD_BUILD);
  assign idx_inc     = idx_r + CW'(1);
  assign cur_inc     = CW'(cur_r) + CW'(1);
  assign advance     = !out_valid_r || out_tready;
  assign issue_emit  = (state_r == ST_EMIT) && advance;

  // segment entries win the single write port; the fill walk only writes untaken cities
  assign wr_en   = seg_vld_r || (fill_vld_r && !taken_r[sp_rdata_r]);
  assign wr_addr = seg_vld_r ? seg_idx_r : cur_r;
  assign wr_data = seg_vld_r ? fp_rdata_r : sp_rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seg_vld_r   <= 1'b0;
      fill_vld_r  <= 1'b0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seg_vld_r  <= state_r == ST_SEG;
      fill_vld_r <= state_r == ST_FILL;
      seg_idx_r  <= idx_r[AW-1:0];
      if (fill_vld_r && !taken_r[sp_rdata_r]) begin
        cur_r <= (cur_inc == n_r) ? '0 : cur_inc[AW-1:0];
      end
      case (state_r)
        ST_IDLE: begin
          if (start_build) begin
            n_r   <= q_entry.n[CW-1:0];
            e_r   <= q_entry.b[AW-1:0];
            cur_r <= q_entry.b[AW-1:0];
            if (q_entry.a < q_entry.b) begin
              idx_r   <= CW'(q_entry.a);
              state_r <= ST_SEG;
            end else begin
              idx_r   <= '0;
              state_r <= ST_FILL;
            end
          end
        end
        ST_SEG: begin
          if (idx_inc == CW'(e_r)) begin
            idx_r   <= '0;
            state_r <= ST_FILL;
          end else begin
            idx_r <= idx_inc;
          end
        end
        ST_FILL: begin
          idx_r <= idx_inc;
          if (idx_inc == n_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // last fill write lands here before the child is read back
          idx_r   <= '0;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (advance) begin
            idx_r <= idx_inc;
            if (idx_inc == n_r) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (advance) begin
        p_vld_r     <= issue_emit;
        p_idx_r     <= idx_r[AW-1:0];
        p_last_r    <= idx_inc == n_r;
        p_wr_r      <= written_r[idx_r[AW-1:0]];
        out_valid_r <= p_vld_r;
        out_pos_r   <= oxc_pkg::CITY_W'(p_idx_r);
        out_city_r  <= p_wr_r ? child_rdata_r : '0;
        out_last_r  <= p_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r   <= '0;
      written_r <= '0;
    end else if (start_build) begin
      taken_r   <= '0;
      written_r <= '0;
    end else begin
      if (seg_vld_r) begin
        taken_r[fp_rdata_r] <= 1'b1;
      end
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_entry.kind == oxc_pkg::CMD_LOAD_FIRST)) begin
      fp_mem[q_entry.a[AW-1:0]] <= q_entry.b;
    end
    fp_rdata_r <= fp_mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_entry.kind == oxc_pkg::CMD_LOAD_SECOND)) begin
      sp_mem[q_entry.a[AW-1:0]] <= q_entry.b;
    end
    sp_rdata_r <= sp_mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      child_mem[wr_addr] <= wr_data;
    end
    if (issue_emit) begin
      child_rdata_r <= child_mem[idx_r[AW-1:0]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(oxc_pkg::OUT_TDATA_W - 2 * oxc_pkg::CITY_W){1'b0}},
                       out_city_r, out_pos_r};
  assign out_tlast  = out_last_r;

  a_one_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(seg_vld_r && fill_vld_r))
    else $error("segment and fill writes overlap");

  a_emit_after_build: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (!seg_vld_r && !fill_vld_r))
    else $error("child read back while writes still pending");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (CW'(cur_r) < n_r))
    else $error("fill position beyond tour length");

  a_stall_keeps_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && !advance) |=> p_vld_r)
    else $error("read stage dropped an entry under stall");

endmodule

// ===== verif/child_tour_checker.sv =====
// checker that predicts every child tour and compares the result stream against it
module child_tour_checker #(
  parameter int MaxTour = oxc_pkg::MAX_CITIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [oxc_pkg::COUNT_W-1:0]     cfg_wr_data,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [oxc_pkg::MODE_W-1:0]      in_tuser,   // mode
  input  logic [oxc_pkg::IN_TDATA_W-1:0]  in_tdata,   // position, city, cut_start, cut_end
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [oxc_pkg::OUT_TDATA_W-1:0] out_tdata,  // child_position, child_city
  input  logic                            out_tlast,
  output int                              failures,
  output int                              outstanding
);

  localparam int CW = oxc_pkg::CITY_W;

  typedef struct {
    logic [CW-1:0] position;
    logic [CW-1:0] city;
    logic          last;
  } child_entry_t;

  child_entry_t                child_q [$];
  logic [CW-1:0]               first_tour  [oxc_pkg::CITY_SPACE];
  logic [CW-1:0]               second_tour [oxc_pkg::CITY_SPACE];
  logic [oxc_pkg::COUNT_W-1:0] city_count;

  // builds the whole child tour and queues its entries in position order
  task automatic predict_child(input logic [CW-1:0] cut_s, input logic [CW-1:0] cut_e);
    logic [CW-1:0] child [oxc_pkg::CITY_SPACE];
    bit            taken [oxc_pkg::CITY_SPACE];
    logic [CW-1:0] c;
    child_entry_t  ent;
    int            n, s, e, cur, i;
    n = city_count;
    if (n == 0) n = 1;
    if (n > MaxTour) n = MaxTour;
    s = cut_s;
    e = cut_e;
    if (s > n - 1) s = n - 1;
    if (e > n - 1) e = n - 1;
    for (i = 0; i < oxc_pkg::CITY_SPACE; i++) begin
      child[i] = '0;
      taken[i] = 1'b0;
    end
    for (i = s; i < e; i++) begin
      child[i] = first_tour[i];
      taken[first_tour[i]] = 1'b1;
    end
    // fill wraps round from the segment end, in second parent order
    cur = e % n;
    for (i = 0; i < n; i++) begin
      c = second_tour[i];
      if (!taken[c]) begin
        child[cur] = c;
        cur = (cur + 1) % n;
      end
    end
    for (i = 0; i < n; i++) begin
      ent.position = CW'(i);
      ent.city     = child[i];
      ent.last     = (i == n - 1);
      child_q      = {child_q, ent};
    end
  endtask

  always @(posedge clk) begin
    child_entry_t got, want;
    if (!rst_n) begin
      child_q.delete();
      city_count = oxc_pkg::CITY_COUNT_RST;
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) city_count = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        got.position = out_tdata[CW-1:0];
        got.city     = out_tdata[2*CW-1:CW];
        got.last     = out_tlast;
        if (child_q.size() == 0) begin
          failures++;
          $error("child_position: transaction with nothing expected, actual %0d", got.position);
        end else begin
          want = child_q.pop_front();
          if (got.position !== want.position) begin
            failures++;
            $error("child_position: expected %0d, actual %0d", want.position, got.position);
          end
          if (got.city !== want.city) begin
            failures++;
            $error("child_city: expected %0d, actual %0d", want.city, got.city);
          end
          if (got.last !== want.last) begin
            failures++;
            $error("last: expected %0d, actual %0d", want.last, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        case (oxc_pkg::cmd_t'(in_tuser))
          oxc_pkg::CMD_LOAD_FIRST:  first_tour[in_tdata[CW-1:0]] = in_tdata[2*CW-1:CW];
          oxc_pkg::CMD_LOAD_SECOND: second_tour[in_tdata[CW-1:0]] = in_tdata[2*CW-1:CW];
          oxc_pkg::CMD_BUILD: predict_child(in_tdata[3*CW-1:2*CW], in_tdata[4*CW-1:3*CW]);
          default: ;
        endcase
      end
      outstanding <= child_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// stimulus and verdict for the order crossover child builder
module testbench;

  localparam int CW = oxc_pkg::CITY_W;
  localparam logic [oxc_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 180;
  localparam int HOLD_CYCLES  = 500;
  localparam int LOAD_SETTLE  = 32;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 400000;

  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            cfg_wr_en   = 1'b0;
  logic [oxc_pkg::COUNT_W-1:0]     cfg_wr_data = '0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [oxc_pkg::MODE_W-1:0]      in_tuser    = '0;
  logic [oxc_pkg::IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  logic [oxc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;

  int check_failures;
  int outstanding;
  int sent_items  = 0;
  int cycle_count = 0;
  bit quiet_in    = 1'b0;
  bit quiet_out   = 1'b0;
  bit hold_req    = 1'b0;

  // the sender's own view of the parent tours, used to build swaps
  logic [CW-1:0] first_copy  [oxc_pkg::CITY_SPACE];
  logic [CW-1:0] second_copy [oxc_pkg::CITY_SPACE];

  order_crossover_child dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  child_tour_checker chk (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .failures(check_failures),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random back-pressure, or a long hold-off when asked for
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet_out || ($urandom_range(99) >= 10);
      end
    end
  end

  // valid stays high after the transaction; callers lower it when a burst ends
  task automatic send_item(input logic [oxc_pkg::MODE_W-1:0] mode, input logic [CW-1:0] pos,
                           input logic [CW-1:0] city, input logic [CW-1:0] cut_s,
                           input logic [CW-1:0] cut_e);
    if (!quiet_in) begin
      while ($urandom_range(99) < 10) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {cut_e, cut_s, city, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode != MODE_UNUSED) sent_items++;
  endtask

  task automatic load_city(input logic [oxc_pkg::MODE_W-1:0] mode, input logic [CW-1:0] pos,
                           input logic [CW-1:0] city);
    if (mode == oxc_pkg::MODE_LOAD_FIRST) first_copy[pos] = city;
    else second_copy[pos] = city;
    send_item(mode, pos, city, CW'($urandom_range(63)), CW'($urandom_range(63)));
  endtask

  task automatic issue_build(input logic [CW-1:0] cut_s, input logic [CW-1:0] cut_e);
    send_item(oxc_pkg::MODE_BUILD, CW'($urandom_range(63)), CW'($urandom_range(63)),
              cut_s, cut_e);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_city_count(input logic [oxc_pkg::COUNT_W-1:0] value);
    wait_drained();
    // loads give no transaction, so let any still queued finish
    repeat (LOAD_SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // both parents get the same random set of n cities, each in its own order
  task automatic reload_parents(input int n);
    logic [CW-1:0] pool [oxc_pkg::CITY_SPACE];
    logic [CW-1:0] tmp;
    int i, j;
    for (i = 0; i < oxc_pkg::CITY_SPACE; i++) pool[i] = CW'(i);
    for (i = oxc_pkg::CITY_SPACE - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = pool[i]; pool[i] = pool[j]; pool[j] = tmp;
    end
    for (i = 0; i < n; i++) load_city(oxc_pkg::MODE_LOAD_FIRST, CW'(i), pool[i]);
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = pool[i]; pool[i] = pool[j]; pool[j] = tmp;
    end
    for (i = 0; i < n; i++) load_city(oxc_pkg::MODE_LOAD_SECOND, CW'(i), pool[i]);
  endtask

  function automatic int tour_n(input logic [oxc_pkg::COUNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > oxc_pkg::CITY_SPACE) return oxc_pkg::CITY_SPACE;
    return count;
  endfunction

  initial begin
    int phase, rounds, n, r, i, j;
    logic [oxc_pkg::COUNT_W-1:0] count;
    logic [oxc_pkg::MODE_W-1:0]  which;
    logic [CW-1:0]               ci, cj;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every parent entry is written before any build reads it
    reload_parents(oxc_pkg::CITY_SPACE);

    issue_build(6'd0, 6'd63);
    issue_build(6'd63, 6'd0);
    issue_build(6'd20, 6'd20);
    issue_build(6'd63, 6'd63);
    issue_build(6'd5, 6'd40);
    // receiver holds off while builds pile up behind it
    hold_req = 1'b1;
    issue_build(6'd0, 6'd0);
    issue_build(6'd10, 6'd50);
    issue_build(6'd40, 6'd10);
    issue_build(6'd1, 6'd62);
    send_item(MODE_UNUSED, 6'd63, 6'd63, 6'd63, 6'd63);
    // duplicated cities make the parents malformed
    load_city(oxc_pkg::MODE_LOAD_FIRST, 6'd3, first_copy[4]);
    load_city(oxc_pkg::MODE_LOAD_SECOND, 6'd7, second_copy[8]);
    issue_build(6'd2, 6'd30);

    set_city_count(7'd0);
    issue_build(6'd0, 6'd0);
    issue_build(6'd63, 6'd63);
    set_city_count(7'd127);
    issue_build(6'd63, 6'd0);
    issue_build(6'd0, 6'd63);
    set_city_count(7'd2);
    issue_build(6'd1, 6'd0);
    issue_build(6'd0, 6'd1);

    phase = 0;
    while (sent_items < RANDOM_ITEMS) begin
      case (phase)
        0:       count = 7'd1;
        1:       count = 7'd2;
        2:       count = 7'd64;
        3:       count = 7'd127;
        4:       count = 7'd0;
        default: count = oxc_pkg::COUNT_W'($urandom_range(3, 16));
      endcase
      quiet_in  = (phase % 4 == 1);
      quiet_out = (phase % 4 == 1);
      set_city_count(count);
      n = tour_n(count);
      reload_parents(n);
      rounds = $urandom_range(4, 10);
      repeat (rounds) begin
        r = $urandom_range(99);
        if (r < 70) begin
          // swap two entries of one parent, keeping it a permutation
          which = $urandom_range(1) ? oxc_pkg::MODE_LOAD_SECOND : oxc_pkg::MODE_LOAD_FIRST;
          i = $urandom_range(n - 1);
          j = $urandom_range(n - 1);
          ci = (which == oxc_pkg::MODE_LOAD_FIRST) ? first_copy[i] : second_copy[i];
          cj = (which == oxc_pkg::MODE_LOAD_FIRST) ? first_copy[j] : second_copy[j];
          load_city(which, CW'(i), cj);
          load_city(which, CW'(j), ci);
          if ($urandom_range(99) < 70) begin
            issue_build(CW'($urandom_range(n - 1)), CW'($urandom_range(n - 1)));
          end else begin
            issue_build(CW'($urandom_range(63)), CW'($urandom_range(63)));
          end
        end else if (r < 80) begin
          send_item(MODE_UNUSED, CW'($urandom_range(63)), CW'($urandom_range(63)),
                    CW'($urandom_range(63)), CW'($urandom_range(63)));
        end else if (r < 90) begin
          which = $urandom_range(1) ? oxc_pkg::MODE_LOAD_SECOND : oxc_pkg::MODE_LOAD_FIRST;
          load_city(which, CW'($urandom_range(63)), CW'($urandom_range(63)));
        end else begin
          issue_build(CW'($urandom_range(63)), CW'($urandom_range(63)));
        end
      end
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (check_failures == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
